### design/tcx_pkg.sv
package tcx_pkg;

   // Opcode field encodings
   localparam logic [3:0] OPC_HALT  = 4'd0;
   localparam logic [3:0] OPC_ADD   = 4'd1;
   localparam logic [3:0] OPC_ADDHI = 4'd2;
   localparam logic [3:0] OPC_SUB   = 4'd3;
   localparam logic [3:0] OPC_BNE   = 4'd4;
   localparam logic [3:0] OPC_BEQ   = 4'd5;
   localparam logic [3:0] OPC_ST    = 4'd6;
   localparam logic [3:0] OPC_STH   = 4'd7;
   localparam logic [3:0] OPC_STB   = 4'd8;
   localparam logic [3:0] OPC_RTE   = 4'd9;

   // Fixed machine constants
   localparam logic [31:0] INSN_BYTES = 32'd4;
   localparam logic [31:0] IRQ_VECTOR = 32'd4;

   // Byte lane enable patterns
   localparam logic [3:0] BE_WORD    = 4'b1111;
   localparam logic [3:0] BE_HALF_LO = 4'b0011;
   localparam logic [3:0] BE_HALF_HI = 4'b1100;
   localparam logic [3:0] BE_BYTE0   = 4'b0001;

   // Decoupling queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Operation class after decode
   typedef enum logic [3:0] {
      OP_HALT,
      OP_ADD,
      OP_ADDHI,
      OP_SUB,
      OP_BNE,
      OP_BEQ,
      OP_ST,
      OP_STH,
      OP_STB,
      OP_RTE,
      OP_BAD
   } tcx_op_type;

   // Classified instruction as held in the queue
   typedef struct packed {
      tcx_op_type  op;
      logic [3:0]  dest;
      logic [3:0]  src1;
      logic [3:0]  src2;
      logic [31:0] imm;
      logic        irq;
   } tcx_item_type;

endpackage

### design/tcx_if.sv
// Instruction channel
interface tcx_req_if;
   logic               valid;
   logic               ready;
   logic [3:0]         opcode;
   logic [3:0]         dest_reg;
   logic [3:0]         src1_reg;
   logic [3:0]         src2_reg;
   logic signed [15:0] immediate;
   logic               irq_pending;

   modport source (
      output valid, opcode, dest_reg, src1_reg, src2_reg, immediate, irq_pending,
      input  ready
   );
   modport sink (
      input  valid, opcode, dest_reg, src1_reg, src2_reg, immediate, irq_pending,
      output ready
   );
endinterface

// Result channel
interface tcx_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] next_pc;
   logic        store_valid;
   logic [31:0] store_addr;
   logic [31:0] store_data;
   logic [3:0]  byte_enable;
   logic        halted;
   logic        bad_opcode;

   modport source (
      output valid, next_pc, store_valid, store_addr, store_data, byte_enable,
             halted, bad_opcode,
      input  ready
   );
   modport sink (
      input  valid, next_pc, store_valid, store_addr, store_data, byte_enable,
             halted, bad_opcode,
      output ready
   );
endinterface

### design/tcx_front.sv
module tcx_front (
   tcx_req_if.sink               req_ch,
   output logic                  push_valid,
   input  logic                  push_ready,
   output tcx_pkg::tcx_item_type push_item
);

   // Pass the handshake straight to the queue
   assign push_valid   = req_ch.valid;
   assign req_ch.ready = push_ready;

   // Classify the opcode and prepare the immediate addend
   always_comb begin
      push_item.dest = req_ch.dest_reg;
      push_item.src1 = req_ch.src1_reg;
      push_item.src2 = req_ch.src2_reg;
      push_item.irq  = req_ch.irq_pending;
      push_item.imm  = {{16{req_ch.immediate[15]}}, req_ch.immediate};
      unique case (req_ch.opcode)
         tcx_pkg::OPC_HALT:  push_item.op = tcx_pkg::OP_HALT;
         tcx_pkg::OPC_ADD:   push_item.op = tcx_pkg::OP_ADD;
         tcx_pkg::OPC_ADDHI: begin
            push_item.op  = tcx_pkg::OP_ADDHI;
            // upper-half immediate
            push_item.imm = {req_ch.immediate, 16'h0000};
         end
         tcx_pkg::OPC_SUB:   push_item.op = tcx_pkg::OP_SUB;
         tcx_pkg::OPC_BNE:   push_item.op = tcx_pkg::OP_BNE;
         tcx_pkg::OPC_BEQ:   push_item.op = tcx_pkg::OP_BEQ;
         tcx_pkg::OPC_ST:    push_item.op = tcx_pkg::OP_ST;
         tcx_pkg::OPC_STH:   push_item.op = tcx_pkg::OP_STH;
         tcx_pkg::OPC_STB:   push_item.op = tcx_pkg::OP_STB;
         tcx_pkg::OPC_RTE:   push_item.op = tcx_pkg::OP_RTE;
         default:            push_item.op = tcx_pkg::OP_BAD;
      endcase
   end

endmodule

### design/tcx_queue.sv
module tcx_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  tcx_pkg::tcx_item_type push_item,
   output logic                  pop_valid,
   input  logic                  pop_take,
   output tcx_pkg::tcx_item_type pop_item
);

   tcx_pkg::tcx_item_type             slot_ff [tcx_pkg::QUEUE_DEPTH];
   logic [tcx_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [tcx_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [tcx_pkg::QCNT_W-1:0]        count_ff, count_in;
   logic                              do_push;
   logic                              do_pop;

   assign push_ready = (count_ff != tcx_pkg::QCNT_W'(tcx_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_take && pop_valid;

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == tcx_pkg::QUEUE_DEPTH - 1) ? '0
                     : wr_ptr_ff + tcx_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == tcx_pkg::QUEUE_DEPTH - 1) ? '0
                     : rd_ptr_ff + tcx_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + tcx_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - tcx_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Slot storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### design/tcx_back.sv
module tcx_back #(
   parameter int REG_COUNT = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   output logic                  q_take,
   input  tcx_pkg::tcx_item_type q_item,
   tcx_rsp_if.source             rsp_ch
);

   localparam int AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

   // Register file: two copies sharing one write port, three read ports total
   logic [31:0]          mem_ab [REG_COUNT];
   logic [31:0]          mem_d  [REG_COUNT];
   logic [REG_COUNT-1:0] vld_ff, vld_in;

   // Execute stage
   logic                  x_vld_ff, x_vld_in;
   tcx_pkg::tcx_item_type x_item_ff;
   logic [31:0]           rd_a_ff, rd_b_ff, rd_d_ff;
   logic                  rv_a_ff, rv_b_ff, rv_d_ff;

   // Last register write, bypassed over the read registers
   logic                  wb_vld_ff, wb_vld_in;
   logic [3:0]            wb_idx_ff;
   logic [31:0]           wb_data_ff;

   // Architectural state
   logic [31:0]           pc_ff, pc_in;
   logic [31:0]           saved_ff, saved_in;
   logic                  ien_ff, ien_in;

   // Output register
   logic                  out_vld_ff, out_vld_in;
   logic [31:0]           out_pc_ff;
   logic                  out_st_ff;
   logic [31:0]           out_addr_ff;
   logic [31:0]           out_data_ff;
   logic [3:0]            out_be_ff;
   logic                  out_halt_ff;
   logic                  out_bad_ff;

   // Execute datapath
   logic                  out_free;
   logic                  x_go;
   logic [31:0]           opa, opb, opd;
   logic [31:0]           b_scaled;
   logic [31:0]           sum;
   logic [31:0]           b_imm;
   logic [31:0]           pc_seq;
   logic [31:0]           pc_mid;
   logic                  ien_mid;
   logic                  wr_en;
   logic [31:0]           wr_data;
   logic                  st_en;
   logic [3:0]            be;
   logic                  halt_flag;
   logic                  bad_flag;
   logic                  irq_take;

   function automatic logic readable(input logic [3:0] idx);
      readable = (idx != '0) && (32'(idx) < REG_COUNT);
   endfunction

   // Resolve a source operand: zero register, bypass, then stored value
   function automatic logic [31:0] operand(input logic [3:0]  idx,
                                           input logic [31:0] rdata,
                                           input logic        rvalid,
                                           input logic        wvld,
                                           input logic [3:0]  widx,
                                           input logic [31:0] wdata);
      logic [31:0] val;
      if (!readable(idx)) begin
         val = '0;
      end else if (wvld && (widx == idx)) begin
         val = wdata;
      end else if (rvalid) begin
         val = rdata;
      end else begin
         val = '0;
      end
      operand = val;
   endfunction

   // Flow control
   assign out_free = !out_vld_ff || rsp_ch.ready;
   assign x_go     = x_vld_ff && out_free;
   assign q_take   = q_valid && (!x_vld_ff || x_go);

   // Register file read, captured as the item enters execute
   always_ff @(posedge clock) begin
      if (q_take) begin
         x_item_ff <= q_item;
         rd_a_ff   <= mem_ab[AW'(q_item.src1)];
         rd_b_ff   <= mem_ab[AW'(q_item.src2)];
         rd_d_ff   <= mem_d[AW'(q_item.dest)];
         rv_a_ff   <= vld_ff[AW'(q_item.src1)];
         rv_b_ff   <= vld_ff[AW'(q_item.src2)];
         rv_d_ff   <= vld_ff[AW'(q_item.dest)];
      end
   end

   // Register file write
   always_ff @(posedge clock) begin
      if (x_go && wr_en) begin
         mem_ab[AW'(x_item_ff.dest)] <= wr_data;
         mem_d[AW'(x_item_ff.dest)]  <= wr_data;
      end
   end

   // Execute one instruction
   always_comb begin
      opa = operand(x_item_ff.src1, rd_a_ff, rv_a_ff, wb_vld_ff, wb_idx_ff, wb_data_ff);
      opb = operand(x_item_ff.src2, rd_b_ff, rv_b_ff, wb_vld_ff, wb_idx_ff, wb_data_ff);
      opd = operand(x_item_ff.dest, rd_d_ff, rv_d_ff, wb_vld_ff, wb_idx_ff, wb_data_ff);

      unique case (x_item_ff.op)
         tcx_pkg::OP_ST:  b_scaled = {opb[29:0], 2'b00};
         tcx_pkg::OP_STH: b_scaled = {opb[30:0], 1'b0};
         default:         b_scaled = opb;
      endcase

      sum    = opa + b_scaled + x_item_ff.imm;
      b_imm  = opb + x_item_ff.imm;
      pc_seq = pc_ff + tcx_pkg::INSN_BYTES;

      pc_mid    = pc_seq;
      ien_mid   = ien_ff;
      wr_en     = 1'b0;
      wr_data   = sum;
      st_en     = 1'b0;
      be        = '0;
      halt_flag = 1'b0;
      bad_flag  = 1'b0;

      unique case (x_item_ff.op)
         tcx_pkg::OP_HALT:  halt_flag = 1'b1;
         tcx_pkg::OP_ADD:   wr_en = readable(x_item_ff.dest);
         tcx_pkg::OP_ADDHI: wr_en = readable(x_item_ff.dest);
         tcx_pkg::OP_SUB: begin
            wr_en   = readable(x_item_ff.dest);
            wr_data = opa - b_imm;
         end
         tcx_pkg::OP_BNE: begin
            if (opa != '0) begin
               pc_mid = pc_seq + b_imm;
            end
         end
         tcx_pkg::OP_BEQ: begin
            if (opa == '0) begin
               pc_mid = pc_seq + b_imm;
            end
         end
         tcx_pkg::OP_ST: begin
            st_en = 1'b1;
            be    = tcx_pkg::BE_WORD;
         end
         tcx_pkg::OP_STH: begin
            st_en = 1'b1;
            be    = sum[0] ? tcx_pkg::BE_HALF_HI : tcx_pkg::BE_HALF_LO;
         end
         tcx_pkg::OP_STB: begin
            st_en = 1'b1;
            be    = tcx_pkg::BE_BYTE0 << sum[1:0];
         end
         tcx_pkg::OP_RTE: begin
            pc_mid  = saved_ff;
            ien_mid = 1'b1;
         end
         tcx_pkg::OP_BAD: begin
            // unknown opcode: state left untouched
            bad_flag = 1'b1;
            pc_mid   = pc_ff;
         end
      endcase

      // Interrupt entry after the instruction
      irq_take = !bad_flag && x_item_ff.irq && ien_mid;
      if (irq_take) begin
         pc_in    = tcx_pkg::IRQ_VECTOR;
         saved_in = pc_mid;
         ien_in   = 1'b0;
      end else begin
         pc_in    = pc_mid;
         saved_in = saved_ff;
         ien_in   = ien_mid;
      end
   end

   // Control next values
   always_comb begin
      x_vld_in = x_vld_ff;
      if (q_take) begin
         x_vld_in = 1'b1;
      end else if (x_go) begin
         x_vld_in = 1'b0;
      end

      out_vld_in = out_vld_ff;
      if (x_go) begin
         out_vld_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_vld_in = 1'b0;
      end

      wb_vld_in = wb_vld_ff || (x_go && wr_en);

      vld_in = vld_ff;
      if (x_go && wr_en) begin
         vld_in[AW'(x_item_ff.dest)] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_vld_ff   <= 1'b0;
         out_vld_ff <= 1'b0;
         wb_vld_ff  <= 1'b0;
         vld_ff     <= '0;
         pc_ff      <= '0;
         saved_ff   <= '0;
         ien_ff     <= 1'b1;
      end else begin
         x_vld_ff   <= x_vld_in;
         out_vld_ff <= out_vld_in;
         wb_vld_ff  <= wb_vld_in;
         vld_ff     <= vld_in;
         if (x_go) begin
            pc_ff    <= pc_in;
            saved_ff <= saved_in;
            ien_ff   <= ien_in;
         end
      end
   end

   // Bypass value and result payload
   always_ff @(posedge clock) begin
      if (x_go && wr_en) begin
         wb_idx_ff  <= x_item_ff.dest;
         wb_data_ff <= wr_data;
      end
      if (x_go) begin
         out_pc_ff   <= pc_in;
         out_st_ff   <= st_en;
         out_addr_ff <= st_en ? sum : '0;
         out_data_ff <= st_en ? opd : '0;
         out_be_ff   <= be;
         out_halt_ff <= halt_flag;
         out_bad_ff  <= bad_flag;
      end
   end

   assign rsp_ch.valid       = out_vld_ff;
   assign rsp_ch.next_pc     = out_pc_ff;
   assign rsp_ch.store_valid = out_st_ff;
   assign rsp_ch.store_addr  = out_addr_ff;
   assign rsp_ch.store_data  = out_data_ff;
   assign rsp_ch.byte_enable = out_be_ff;
   assign rsp_ch.halted      = out_halt_ff;
   assign rsp_ch.bad_opcode  = out_bad_ff;

endmodule

### design/toy_cpu_execute_unit.sv
// Channel   Direction  Carries
// req_ch    in         opcode, dest_reg, src1_reg, src2_reg, immediate, irq_pending
// rsp_ch    out        next_pc, store_valid/addr/data, byte_enable, halted, bad_opcode
//
// One instruction per cycle sustained while rsp_ch is ready; a req transfer writes a
// queue slot, the register file read is registered as the item enters execute, and
// execute then fills the output register that drives rsp valid. The execute step
// updates pc and registers together, so that loop sets the rate.
// Synchronous reset clears registers, pc, saved pc and queue; interrupts enabled.
// A stalled rsp_ch fills the output register, execute stage and queue in turn
// before req_ch.ready drops.
module toy_cpu_execute_unit #(
   parameter int REG_COUNT = 16
) (
   input logic       clock,
   input logic       reset,
   tcx_req_if.sink   req_ch,
   tcx_rsp_if.source rsp_ch
);

   logic                  push_valid;
   logic                  push_ready;
   tcx_pkg::tcx_item_type push_item;
   logic                  pop_valid;
   logic                  pop_take;
   tcx_pkg::tcx_item_type pop_item;

   // Decode and classify
   tcx_front u_front (
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   // Decoupling queue
   tcx_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_take   (pop_take),
      .pop_item   (pop_item)
   );

   // Register file, execute and result register
   tcx_back #(
      .REG_COUNT (REG_COUNT)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (pop_valid),
      .q_take  (pop_take),
      .q_item  (pop_item),
      .rsp_ch  (rsp_ch)
   );

endmodule

### verif/tb.sv
`timescale 1ns / 100ps

module tb;

   localparam int          NUM_GPR      = 16;
   localparam int          RANDOM_INSNS = 1950;
   localparam int          STALL_LIMIT  = 2000;
   localparam int          DRAIN_CYCLES = 10;
   localparam int          SHOW_MAX     = 10;
   // opcodes with no defined operation
   localparam logic [3:0]  OPC_UNK_LO   = 4'd10;
   localparam logic [3:0]  OPC_UNK_HI   = 4'd15;
   localparam logic [15:0] IMM_MAX      = 16'h7FFF;
   localparam logic [15:0] IMM_MIN      = 16'h8000;
   localparam logic [15:0] IMM_ALL_ONES = 16'hFFFF;

   typedef struct packed {
      logic [3:0]  opcode;
      logic [3:0]  dest;
      logic [3:0]  src1;
      logic [3:0]  src2;
      logic [15:0] imm;
      logic        irq;
   } insn_type;

   typedef struct packed {
      logic [31:0] next_pc;
      logic        store_valid;
      logic [31:0] store_addr;
      logic [31:0] store_data;
      logic [3:0]  byte_enable;
      logic        halted;
      logic        bad_opcode;
   } outcome_type;

   logic clock;
   logic reset;

   tcx_req_if req_ch ();
   tcx_rsp_if rsp_ch ();

   toy_cpu_execute_unit #(
      .REG_COUNT (NUM_GPR)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // architectural state mirrored by the predictor
   logic [31:0] gpr [NUM_GPR];
   logic [31:0] pc;
   logic [31:0] epc;
   logic        irq_en;

   insn_type    pending_insns [$];
   outcome_type retired_q [$];

   int          n_accepted;
   int          mismatches;
   int          send_gap;
   int          stall_left;
   int          hold_left;
   int          rx_cycles;
   int          idle_cycles;
   logic        req_took;
   insn_type    drv_insn;
   insn_type    seen_insn;
   outcome_type want;
   outcome_type got;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------
   function automatic logic [31:0] read_gpr(logic [3:0] idx);
      if (idx == 4'd0 || idx >= NUM_GPR)
         return 32'd0;
      return gpr[idx];
   endfunction

   function automatic void write_gpr(logic [3:0] idx, logic [31:0] val);
      if (idx != 4'd0 && idx < NUM_GPR)
         gpr[idx] = val;
   endfunction

   function automatic outcome_type execute_insn(insn_type ins);
      outcome_type res;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] imm32;
      res   = '0;
      a     = read_gpr(ins.src1);
      b     = read_gpr(ins.src2);
      imm32 = {{16{ins.imm[15]}}, ins.imm};
      if (ins.opcode > tcx_pkg::OPC_RTE) begin
         // unknown opcode: flagged, nothing else moves
         res.bad_opcode = 1'b1;
      end else begin
         pc = pc + tcx_pkg::INSN_BYTES;
         case (ins.opcode)
            tcx_pkg::OPC_HALT: begin
               res.halted = 1'b1;
            end
            tcx_pkg::OPC_ADD: begin
               write_gpr(ins.dest, a + b + imm32);
            end
            tcx_pkg::OPC_ADDHI: begin
               write_gpr(ins.dest, a + b + (imm32 << 16));
            end
            tcx_pkg::OPC_SUB: begin
               write_gpr(ins.dest, a - (b + imm32));
            end
            tcx_pkg::OPC_BNE: begin
               if (a != 32'd0)
                  pc = pc + b + imm32;
            end
            tcx_pkg::OPC_BEQ: begin
               if (a == 32'd0)
                  pc = pc + b + imm32;
            end
            tcx_pkg::OPC_ST: begin
               res.store_valid = 1'b1;
               res.store_addr  = a + (b << 2) + imm32;
               res.byte_enable = tcx_pkg::BE_WORD;
            end
            tcx_pkg::OPC_STH: begin
               res.store_valid = 1'b1;
               res.store_addr  = a + (b << 1) + imm32;
               res.byte_enable = res.store_addr[0] ? tcx_pkg::BE_HALF_HI
                                                   : tcx_pkg::BE_HALF_LO;
            end
            tcx_pkg::OPC_STB: begin
               res.store_valid = 1'b1;
               res.store_addr  = a + b + imm32;
               res.byte_enable = tcx_pkg::BE_BYTE0 << res.store_addr[1:0];
            end
            default: begin
               // return from exception
               pc     = epc;
               irq_en = 1'b1;
            end
         endcase
         if (res.store_valid)
            res.store_data = read_gpr(ins.dest);
         // interrupt is taken after the instruction itself
         if (ins.irq && irq_en) begin
            epc    = pc;
            pc     = tcx_pkg::IRQ_VECTOR;
            irq_en = 1'b0;
         end
      end
      res.next_pc = pc;
      return res;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   function automatic insn_type mk(logic [3:0] op, logic [3:0] rd, logic [3:0] rs1,
                                   logic [3:0] rs2, logic [15:0] imm, logic irq);
      insn_type ins;
      ins.opcode = op;
      ins.dest   = rd;
      ins.src1   = rs1;
      ins.src2   = rs2;
      ins.imm    = imm;
      ins.irq    = irq;
      return ins;
   endfunction

   function automatic insn_type rand_insn();
      insn_type ins;
      int       r;
      r = $urandom_range(0, 99);
      if (r < 8)
         ins.opcode = 4'($urandom_range(OPC_UNK_LO, OPC_UNK_HI));
      else
         ins.opcode = 4'($urandom_range(tcx_pkg::OPC_HALT, tcx_pkg::OPC_RTE));
      ins.dest = 4'($urandom_range(0, NUM_GPR - 1));
      ins.src1 = 4'($urandom_range(0, NUM_GPR - 1));
      ins.src2 = 4'($urandom_range(0, NUM_GPR - 1));
      // register zero shows up more often so that beq/bne go both ways
      if ($urandom_range(0, 7) == 0)
         ins.src1 = 4'd0;
      r = $urandom_range(0, 99);
      case (r % 4)
         0: ins.imm = IMM_MAX;
         1: ins.imm = IMM_MIN;
         2: ins.imm = IMM_ALL_ONES;
         default: ins.imm = 16'd0;
      endcase
      if (r >= 15 && r < 60)
         ins.imm = 16'($signed($urandom_range(0, 128)) - 64);
      else if (r >= 60)
         ins.imm = 16'($urandom);
      ins.irq = ($urandom_range(0, 9) == 0);
      return ins;
   endfunction

   // mostly short gaps, a few long ones, none at all during calm stretches
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (((n_accepted >> 8) % 3) == 1 || r < 55)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // ------------------------------------------------------------------
   // Instruction driver
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap = 0;
      end else if (!req_ch.valid || req_took) begin
         if (send_gap > 0) begin
            send_gap--;
            req_ch.valid <= 1'b0;
         end else if (pending_insns.size() > 0) begin
            drv_insn = pending_insns.pop_front();
            req_ch.opcode      <= drv_insn.opcode;
            req_ch.dest_reg    <= drv_insn.dest;
            req_ch.src1_reg    <= drv_insn.src1;
            req_ch.src2_reg    <= drv_insn.src2;
            req_ch.immediate   <= drv_insn.imm;
            req_ch.irq_pending <= drv_insn.irq;
            req_ch.valid       <= 1'b1;
            send_gap = pick_gap();
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Result receiver: random stalls plus long hold-offs to back up the pipe
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left = 0;
         hold_left  = 0;
         rx_cycles  = 0;
      end else begin
         rx_cycles++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (rx_cycles == 400 || $urandom_range(0, 1499) == 0) begin
            hold_left = $urandom_range(60, 120) - 1;
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: predict on each instruction transfer, check each result transfer
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_GPR; i++)
            gpr[i] = 32'd0;
         pc       = 32'd0;
         epc      = 32'd0;
         irq_en   = 1'b1;
         req_took = 1'b0;
      end else begin
         req_took = req_ch.valid && req_ch.ready;
         if (req_took) begin
            seen_insn = mk(req_ch.opcode, req_ch.dest_reg, req_ch.src1_reg,
                           req_ch.src2_reg, req_ch.immediate, req_ch.irq_pending);
            retired_q.push_back(execute_insn(seen_insn));
            n_accepted++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = {rsp_ch.next_pc, rsp_ch.store_valid, rsp_ch.store_addr,
                   rsp_ch.store_data, rsp_ch.byte_enable, rsp_ch.halted,
                   rsp_ch.bad_opcode};
            if (retired_q.size() == 0) begin
               mismatches++;
               if (mismatches <= SHOW_MAX)
                  $display("%0t: result with nothing outstanding: pc=%h st=%b",
                           $realtime, got.next_pc, got.store_valid);
            end else begin
               want = retired_q.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= SHOW_MAX) begin
                     $display("%0t: expected pc=%h st=%b addr=%h data=%h be=%b hlt=%b bad=%b",
                              $realtime, want.next_pc, want.store_valid, want.store_addr,
                              want.store_data, want.byte_enable, want.halted,
                              want.bad_opcode);
                     $display("%0t: actual   pc=%h st=%b addr=%h data=%h be=%b hlt=%b bad=%b",
                              $realtime, got.next_pc, got.store_valid, got.store_addr,
                              got.store_data, got.byte_enable, got.halted,
                              got.bad_opcode);
                  end
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: too long without any transfer on either side
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("toy_cpu_execute_unit test failed");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.opcode      = tcx_pkg::OPC_HALT;
      req_ch.dest_reg    = 4'd0;
      req_ch.src1_reg    = 4'd0;
      req_ch.src2_reg    = 4'd0;
      req_ch.immediate   = 16'd0;
      req_ch.irq_pending = 1'b0;
      rsp_ch.ready       = 1'b0;
      n_accepted         = 0;
      mismatches         = 0;

      // directed: field extremes, every operation, the corner cases
      pending_insns.push_back(mk(tcx_pkg::OPC_ADD,   4'd1, 4'd0, 4'd0, IMM_MAX, 1'b0));
      pending_insns.push_back(mk(tcx_pkg::OPC_ADDHI, 4'd2, 4'd1, 4'd0, IMM_MIN, 1'b0));
      pending_insns.push_back(mk(tcx_pkg::OPC_ADD,   4'd3, 4'd2, 4'd1, IMM_ALL_ONES, 1'b0));
      pending_insns.push_back(mk(tcx_pkg::OPC_SUB,   4'd4, 4'd3, 4'd1, IMM_MIN, 1'b0));
      // writes to register zero are dropped
      pending_insns.push_back(mk(tcx_pkg::OPC_ADD,   4'd0, 4'd1, 4'd2, 16'd5, 1'b0));
      pending_insns.push_back(mk(tcx_pkg::OPC_ADD,   4'd15, 4'd0, 4'd0, 16'd64, 1'b0));
      pending_insns.push_back(mk(tcx_pkg::OPC_ST,    4'd3, 4'd15, 4'd1, 16'd0, 1'b0));
      // halfword, even then odd address
      pending_insns.push_back(mk(tcx_pkg::OPC_STH,   4'd4, 4'd15, 4'd0, 16'd0, 1'b0));
      pending_insns.push_back(mk(tcx_pkg::OPC_STH,   4'd0, 4'd15, 4'd0, 16'd1, 1'b0));
      // byte stores on each lane
      for (int k = 0; k < 4; k++)
         pending_insns.push_back(mk(tcx_pkg::OPC_STB, 4'd2, 4'd15, 4'd0, 16'(k), 1'b0));
      // branches, taken and not taken
      pending_insns.push_back(mk(tcx_pkg::OPC_BNE,   4'd0, 4'd1, 4'd0, 16'hFFF8, 1'b0));
      pending_insns.push_back(mk(tcx_pkg::OPC_BNE,   4'd0, 4'd0, 4'd15, 16'd8, 1'b0));
      pending_insns.push_back(mk(tcx_pkg::OPC_BEQ,   4'd0, 4'd0, 4'd15, 16'd100, 1'b0));
      pending_insns.push_back(mk(tcx_pkg::OPC_BEQ,   4'd0, 4'd1, 4'd15, 16'd100, 1'b0));
      pending_insns.push_back(mk(tcx_pkg::OPC_HALT,  4'd0, 4'd0, 4'd0, 16'd0, 1'b0));
      // unknown opcodes ignore a pending interrupt
      pending_insns.push_back(mk(OPC_UNK_LO, 4'd5, 4'd1,  4'd2, IMM_MAX, 1'b1));
      pending_insns.push_back(mk(OPC_UNK_HI, 4'd15, 4'd15, 4'd15, IMM_ALL_ONES, 1'b1));
      // interrupt taken, then masked, then re-enabled by rte
      pending_insns.push_back(mk(tcx_pkg::OPC_ADD,   4'd6, 4'd1, 4'd1, 16'd1, 1'b1));
      pending_insns.push_back(mk(tcx_pkg::OPC_HALT,  4'd0, 4'd0, 4'd0, 16'd0, 1'b1));
      pending_insns.push_back(mk(tcx_pkg::OPC_RTE,   4'd0, 4'd0, 4'd0, 16'd0, 1'b0));
      pending_insns.push_back(mk(tcx_pkg::OPC_HALT,  4'd0, 4'd0, 4'd0, 16'd0, 1'b1));
      pending_insns.push_back(mk(tcx_pkg::OPC_RTE,   4'd0, 4'd0, 4'd0, 16'd0, 1'b1));

      for (int n = 0; n < RANDOM_INSNS; n++)
         pending_insns.push_back(rand_insn());

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // drain everything, then let the pipe settle
      while (pending_insns.size() != 0 || req_ch.valid || retired_q.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && retired_q.size() == 0)
         $display("toy_cpu_execute_unit test passed");
      else
         $display("toy_cpu_execute_unit test failed");
      $finish;
   end

endmodule
